// File: rtl/tcrc_pkg.sv
// ----------------------------------------------------------------------------
// TCP congestion and RTO control package
// Event codes, register indexes, widths and reset values shared by the block.
// ----------------------------------------------------------------------------
`default_nettype none

package tcrc_pkg;

	// event codes carried on the input tuser
	localparam logic [2:0] ACT_OPEN    = 3'd0;
	localparam logic [2:0] ACT_ACK     = 3'd1;
	localparam logic [2:0] ACT_RTT     = 3'd2;
	localparam logic [2:0] ACT_TIMEOUT = 3'd3;
	localparam logic [2:0] ACT_SEND    = 3'd4;

	// configuration register indexes
	localparam logic [2:0] REG_SEGMENT_SIZE      = 3'd0;
	localparam logic [2:0] REG_INITIAL_THRESHOLD = 3'd1;
	localparam logic [2:0] REG_INITIAL_VARIANCE  = 3'd2;
	localparam logic [2:0] REG_INITIAL_TIMEOUT   = 3'd3;
	localparam logic [2:0] REG_TIMEOUT_FLOOR     = 3'd4;
	localparam logic [2:0] REG_TIMEOUT_CEILING   = 3'd5;

	// field widths
	localparam int SEQ_W  = 32;
	localparam int MS_W   = 16;
	localparam int BUF_W  = 17;
	localparam int LEN_W  = 16;
	localparam int RTRY_W = 8;
	localparam int IN_W   = 56;
	localparam int OUT_W  = 160;

	// reset values
	localparam logic [15:0] RST_SEGMENT_SIZE      = 16'd1460;
	localparam logic [31:0] RST_INITIAL_THRESHOLD = 32'd65535;
	localparam logic [15:0] RST_INITIAL_VARIANCE  = 16'd250;
	localparam logic [15:0] RST_INITIAL_TIMEOUT   = 16'd1000;
	localparam logic [15:0] RST_TIMEOUT_FLOOR     = 16'd200;
	localparam logic [15:0] RST_TIMEOUT_CEILING   = 16'd64000;

	localparam int DEF_BUFFER_BYTES = 65536;

	// saturating 32-bit add
	function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction

endpackage

`default_nettype wire

// File: rtl/tcp_congestion_and_rto_control.sv
// ----------------------------------------------------------------------------
// TCP congestion and RTO control
// Reno congestion window and Jacobson-style retransmission timeout for one
// connection, driven by a stream of events with one result per event.
// ----------------------------------------------------------------------------
// Each input transaction carries one event (tuser: open, ack, rtt sample,
// timeout, send request) and yields exactly one output transaction with the
// grant (length, sequence, buffer offset, retransmit flag in tuser) and the
// window, threshold, RTO and retry count after the event. Events are handled
// one at a time: open, timeout and unknown codes pass EXEC to FIN, rtt samples
// and rejected or slow-start acks add EXEC2, send requests EXEC2 and EXEC3, and
// an ack in congestion avoidance EXEC2, DIV and GROW, where a radix-2 restoring
// divider yields one quotient bit per cycle to form segment_size^2/cwnd. The
// result sits in an output register, so the next event is accepted while the
// previous result still waits for m_axis_tready. Configuration writes are
// taken at any cycle and must only be issued while the block is idle.
`default_nettype none

module tcp_congestion_and_rto_control
	import tcrc_pkg::*;
#(
	parameter int BUFFER_BYTES = DEF_BUFFER_BYTES
) (
	input  wire                clk,
	input  wire                arst_n,
	// configuration
	input  wire                cfg_we,
	input  wire  [2:0]         cfg_addr,
	input  wire  [31:0]        cfg_wdata,
	// events in
	input  wire                s_axis_tvalid,
	output logic               s_axis_tready,
	input  wire  [IN_W-1:0]    s_axis_tdata,  // value[31:0], buffered_bytes[48:32], zero pad
	input  wire  [2:0]         s_axis_tuser,  // action[2:0]
	// results out
	output logic               m_axis_tvalid,
	input  wire                m_axis_tready,
	output logic [OUT_W-1:0]   m_axis_tdata,  // send_len[15:0], send_seq[47:16],
	                                          // send_offset[64:48], window_now[96:65],
	                                          // threshold_now[128:97], timeout_now[144:129],
	                                          // retry_count[152:145], zero pad
	output logic               m_axis_tuser   // is_retransmit
);

	// buffer limit compare width
	localparam int LimW = $clog2(BUFFER_BYTES + 1);
	localparam int CmpW = (LimW > BUF_W) ? LimW : BUF_W;
	localparam logic [CmpW-1:0] BufLim = CmpW'(BUFFER_BYTES);

	// sequencer states
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_EXEC  = 3'd1;
	localparam logic [2:0] ST_EXEC2 = 3'd2;
	localparam logic [2:0] ST_EXEC3 = 3'd3;
	localparam logic [2:0] ST_DIV   = 3'd4;
	localparam logic [2:0] ST_GROW  = 3'd5;
	localparam logic [2:0] ST_FIN   = 3'd6;

	logic [2:0] state_q;

	// configuration registers
	logic [15:0] seg_q, ivar_q, ito_q, floor_q, ceil_q;
	logic [31:0] ithr_q;

	// connection state
	logic [31:0] cwnd_q, thr_q, una_q, nxt_q;
	logic [15:0] srtt_q, var_q, rto_q;
	logic [7:0]  retries_q;

	// event being worked on
	logic [2:0]       act_q;
	logic [31:0]      val_q;
	logic [BUF_W-1:0] buf_q;

	// intermediates
	logic [31:0]      adv_q, span_q, flight_q, room_q;
	logic [BUF_W-1:0] share_q;

	// divider: dividend shifts out of quo_q while quotient bits shift in
	logic [31:0] quo_q, rem_q, dvs_q;
	logic [4:0]  cnt_q;

	// grant
	logic [15:0]      g_len_q;
	logic [31:0]      g_seq_q;
	logic [BUF_W-1:0] g_off_q;
	logic             g_re_q;

	// output register
	logic             m_valid_q;
	logic [15:0]      o_len_q;
	logic [31:0]      o_seq_q;
	logic [BUF_W-1:0] o_off_q;
	logic             o_re_q;
	logic [31:0]      o_win_q, o_thr_q;
	logic [15:0]      o_rto_q;
	logic [7:0]       o_rtry_q;

	// ------------------------------------------------------------------------
	// Input decode
	// ------------------------------------------------------------------------
	logic [CmpW-1:0]  buf_in_ext;
	logic [BUF_W-1:0] buf_in_clamped;
	logic             in_fire, out_free;

	assign in_fire    = s_axis_tvalid && s_axis_tready;
	assign out_free   = !m_valid_q || m_axis_tready;
	assign buf_in_ext = CmpW'(s_axis_tdata[48:32]);
	assign buf_in_clamped = (buf_in_ext > BufLim) ? BufLim[BUF_W-1:0] : s_axis_tdata[48:32];

	// ------------------------------------------------------------------------
	// RTT sample arithmetic
	// ------------------------------------------------------------------------
	logic [15:0] samp, rtt_diff;
	logic [18:0] srtt_sum;
	logic [17:0] var_sum;
	logic [18:0] rto_raw;
	logic [15:0] rto_clamped;
	logic [18:0] rto_floored;

	assign samp     = (val_q[31:16] != 16'd0) ? 16'hFFFF : val_q[15:0];
	assign rtt_diff = (srtt_q > samp) ? (srtt_q - samp) : (samp - srtt_q);
	assign srtt_sum = {srtt_q, 3'b000} - 19'(srtt_q) + 19'(samp);
	assign var_sum  = 18'({var_q, 1'b0}) + 18'(var_q) + 18'(rtt_diff);
	assign rto_raw  = 19'(srtt_q) + 19'({var_q, 2'b00});
	assign rto_floored = (rto_raw < 19'(floor_q)) ? 19'(floor_q) : rto_raw;
	assign rto_clamped = (rto_floored > 19'(ceil_q)) ? ceil_q : rto_floored[15:0];

	// ------------------------------------------------------------------------
	// Timeout arithmetic
	// ------------------------------------------------------------------------
	logic [31:0]      half_win, thr_floor;
	logic [16:0]      rto_dbl;
	logic [BUF_W-1:0] rtx_len;

	assign half_win  = {1'b0, cwnd_q[31:1]};
	assign thr_floor = 32'({seg_q, 1'b0});
	assign rto_dbl   = {rto_q, 1'b0};
	assign rtx_len   = (buf_q < {1'b0, seg_q}) ? buf_q : {1'b0, seg_q};

	// ------------------------------------------------------------------------
	// Send and ack arithmetic
	// ------------------------------------------------------------------------
	logic [BUF_W-1:0] room_share;
	logic [15:0]      snd_len;
	logic             ack_ok;

	assign room_share = (room_q < 32'(share_q)) ? room_q[BUF_W-1:0] : share_q;
	assign snd_len    = (room_share < {1'b0, seg_q}) ? room_share[15:0] : seg_q;
	assign ack_ok     = (adv_q != 32'd0) && (adv_q <= span_q);

	// one restoring step: bring down the next dividend bit, subtract if it fits
	logic [32:0] rem_sh;
	logic        div_fit;

	assign rem_sh  = {rem_q, quo_q[31]};
	assign div_fit = rem_sh >= {1'b0, dvs_q};

	// ------------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_q   <= RST_SEGMENT_SIZE;
			ithr_q  <= RST_INITIAL_THRESHOLD;
			ivar_q  <= RST_INITIAL_VARIANCE;
			ito_q   <= RST_INITIAL_TIMEOUT;
			floor_q <= RST_TIMEOUT_FLOOR;
			ceil_q  <= RST_TIMEOUT_CEILING;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_SEGMENT_SIZE:      seg_q   <= cfg_wdata[15:0];
				REG_INITIAL_THRESHOLD: ithr_q  <= cfg_wdata;
				REG_INITIAL_VARIANCE:  ivar_q  <= cfg_wdata[15:0];
				REG_INITIAL_TIMEOUT:   ito_q   <= cfg_wdata[15:0];
				REG_TIMEOUT_FLOOR:     floor_q <= cfg_wdata[15:0];
				REG_TIMEOUT_CEILING:   ceil_q  <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------------
	// Event sequencer and connection state
	// ------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cwnd_q    <= 32'(RST_SEGMENT_SIZE);
			thr_q     <= RST_INITIAL_THRESHOLD;
			una_q     <= 32'd0;
			nxt_q     <= 32'd0;
			srtt_q    <= 16'd0;
			var_q     <= RST_INITIAL_VARIANCE;
			rto_q     <= RST_INITIAL_TIMEOUT;
			retries_q <= 8'd0;
			cnt_q     <= 5'd0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						act_q   <= s_axis_tuser;
						val_q   <= s_axis_tdata[31:0];
						buf_q   <= buf_in_clamped;
						g_len_q <= 16'd0;
						g_seq_q <= 32'd0;
						g_off_q <= '0;
						g_re_q  <= 1'b0;
						state_q <= ST_EXEC;
					end
				end

				ST_EXEC: begin
					unique case (act_q)
						ACT_OPEN: begin
							cwnd_q    <= 32'(seg_q);
							thr_q     <= ithr_q;
							una_q     <= val_q;
							nxt_q     <= val_q;
							srtt_q    <= 16'd0;
							var_q     <= ivar_q;
							rto_q     <= ito_q;
							retries_q <= 8'd0;
							state_q   <= ST_FIN;
						end
						ACT_ACK: begin
							adv_q   <= val_q - una_q;
							span_q  <= nxt_q - una_q;
							state_q <= ST_EXEC2;
						end
						ACT_RTT: begin
							if (srtt_q == 16'd0) begin
								srtt_q <= samp;
								var_q  <= {1'b0, samp[15:1]};
							end else begin
								srtt_q <= srtt_sum[18:3];
								var_q  <= var_sum[17:2];
							end
							state_q <= ST_EXEC2;
						end
						ACT_TIMEOUT: begin
							thr_q  <= (half_win < thr_floor) ? thr_floor : half_win;
							cwnd_q <= 32'(seg_q);
							rto_q  <= (rto_dbl > {1'b0, ceil_q}) ? ceil_q : rto_dbl[15:0];
							if (rtx_len != '0) begin
								g_len_q <= rtx_len[15:0];
								g_seq_q <= una_q;
								g_re_q  <= 1'b1;
								nxt_q   <= una_q + 32'(rtx_len);
								if (retries_q != 8'hFF) begin
									retries_q <= retries_q + 8'd1;
								end
							end
							state_q <= ST_FIN;
						end
						ACT_SEND: begin
							flight_q <= nxt_q - una_q;
							state_q  <= ST_EXEC2;
						end
						default: state_q <= ST_FIN;
					endcase
				end

				ST_EXEC2: begin
					unique case (act_q)
						ACT_ACK: begin
							if (ack_ok) begin
								una_q     <= val_q;
								retries_q <= 8'd0;
								if (cwnd_q < thr_q) begin
									cwnd_q  <= sat_add32(cwnd_q, 32'(seg_q));
									state_q <= ST_FIN;
								end else begin
									// congestion avoidance: start seg^2 / cwnd
									quo_q   <= 32'(seg_q) * 32'(seg_q);
									dvs_q   <= (cwnd_q == 32'd0) ? 32'd1 : cwnd_q;
									rem_q   <= 32'd0;
									cnt_q   <= 5'd0;
									state_q <= ST_DIV;
								end
							end else begin
								state_q <= ST_FIN;
							end
						end
						ACT_RTT: begin
							rto_q   <= rto_clamped;
							state_q <= ST_FIN;
						end
						ACT_SEND: begin
							room_q  <= (flight_q < cwnd_q) ? (cwnd_q - flight_q) : 32'd0;
							share_q <= (32'(buf_q) >= flight_q) ?
							           (buf_q - flight_q[BUF_W-1:0]) : '0;
							state_q <= ST_EXEC3;
						end
						default: state_q <= ST_FIN;
					endcase
				end

				ST_EXEC3: begin
					if (snd_len != 16'd0) begin
						g_len_q <= snd_len;
						g_seq_q <= nxt_q;
						g_off_q <= flight_q[BUF_W-1:0];
						nxt_q   <= nxt_q + 32'(snd_len);
					end
					state_q <= ST_FIN;
				end

				ST_DIV: begin
					rem_q <= div_fit ? (rem_sh[31:0] - dvs_q) : rem_sh[31:0];
					quo_q <= {quo_q[30:0], div_fit};
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd31) begin
						state_q <= ST_GROW;
					end
				end

				ST_GROW: begin
					cwnd_q  <= sat_add32(cwnd_q, quo_q);
					state_q <= ST_FIN;
				end

				ST_FIN: begin
					// hold here until the output register is free
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end

				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// result valid: set as the result is posted, drop once the transaction completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (state_q == ST_FIN && out_free) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	// result payload, loaded as the result is posted
	always_ff @(posedge clk) begin
		if (state_q == ST_FIN && out_free) begin
			o_len_q  <= g_len_q;
			o_seq_q  <= g_seq_q;
			o_off_q  <= g_off_q;
			o_re_q   <= g_re_q;
			o_win_q  <= cwnd_q;
			o_thr_q  <= thr_q;
			o_rto_q  <= rto_q;
			o_rtry_q <= retries_q;
		end
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tuser  = o_re_q;
	assign m_axis_tdata  = {7'd0, o_rtry_q, o_rto_q, o_thr_q, o_win_q, o_off_q, o_seq_q, o_len_q};

endmodule

`default_nettype wire

// File: tb/sv/tb_tcp_congestion_and_rto_control.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for tcp_congestion_and_rto_control
// Drives event streams (open, ack, rtt sample, timeout, send request and
// unused codes) through the slave stream under random valid and ready gaps.
// A local connection model predicts one result per accepted event. The
// monitor compares every result field by field against the oldest pending
// prediction. Register settings change only while the block is idle.
// ----------------------------------------------------------------------------

module tb_tcp_congestion_and_rto_control;
	import tcrc_pkg::*;

	// codes the package leaves unnamed: spare event codes and register slots
	localparam logic [2:0] ACT_SPARE_5 = 3'd5;
	localparam logic [2:0] ACT_SPARE_6 = 3'd6;
	localparam logic [2:0] ACT_SPARE_7 = 3'd7;
	localparam logic [2:0] REG_SPARE_6 = 3'd6;
	localparam logic [2:0] REG_SPARE_7 = 3'd7;

	// cycles to let pass once everything is back; the slowest event is an ack in
	// congestion avoidance
	localparam int SETTLE_CYCLES = 40;
	// idle probability per side, percent
	localparam int GAP_PCT = 35;
	// mismatch lines printed before going quiet (all are still counted)
	localparam int PRINT_LIMIT = 40;

	typedef struct packed {
		logic [2:0]  action;
		logic [31:0] value;
		logic [16:0] buffered;
	} tcp_event_t;

	typedef struct packed {
		logic [15:0] send_len;
		logic [31:0] send_seq;
		logic [16:0] send_offset;
		logic        is_retransmit;
		logic [31:0] window_now;
		logic [31:0] threshold_now;
		logic [15:0] timeout_now;
		logic [7:0]  retry_count;
	} tcp_status_t;

	typedef struct packed {
		logic [31:0] cwnd;
		logic [31:0] ssthresh;
		logic [31:0] snd_una;
		logic [31:0] snd_nxt;
		logic [15:0] srtt;
		logic [15:0] rttvar;
		logic [15:0] rto;
		logic [7:0]  retries;
	} conn_state_t;

	typedef struct packed {
		logic [15:0] mss;
		logic [31:0] init_ssthresh;
		logic [15:0] init_rttvar;
		logic [15:0] init_rto;
		logic [15:0] rto_min;
		logic [15:0] rto_max;
	} conn_cfg_t;

	// ------------------------------------------------------------------------
	// DUT hookup; every input starts at a known value
	// ------------------------------------------------------------------------
	logic              clk           = 1'b0;
	logic              arst_n        = 1'b0;
	logic              cfg_we        = 1'b0;
	logic [2:0]        cfg_addr      = '0;
	logic [31:0]       cfg_wdata     = '0;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	logic [IN_W-1:0]   s_axis_tdata  = '0;  // value[31:0], buffered_bytes[48:32], zero pad
	logic [2:0]        s_axis_tuser  = '0;  // action[2:0]
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic [OUT_W-1:0]  m_axis_tdata;        // send_len[15:0], send_seq[47:16],
	                                        // send_offset[64:48], window_now[96:65],
	                                        // threshold_now[128:97], timeout_now[144:129],
	                                        // retry_count[152:145], zero pad
	logic              m_axis_tuser;        // is_retransmit

	tcp_congestion_and_rto_control dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_addr     (cfg_addr),
		.cfg_wdata    (cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	always #1 clk = ~clk;

	// ------------------------------------------------------------------------
	// Shared testbench state
	// ------------------------------------------------------------------------
	conn_cfg_t   cfg_shadow;         // register contents as the block should hold them
	conn_state_t live_conn;          // connection as seen by accepted transactions
	conn_state_t plan_conn;          // connection as the stimulus planner sees it
	tcp_event_t  event_on_bus;       // event currently offered on the slave side
	tcp_event_t  pending_events[$];  // events waiting for the driver
	tcp_status_t expected_status[$]; // predicted results, oldest first

	int n_queued     = 0;
	int n_accepted   = 0;
	int n_results    = 0;
	int n_grants     = 0;
	int n_retx       = 0;
	int n_divisions  = 0;
	int n_settings   = 0;
	int error_count  = 0;

	// ------------------------------------------------------------------------
	// Connection model: apply one event to a connection, return the result.
	// divided flags an accepted ack in congestion avoidance (the slow path).
	// ------------------------------------------------------------------------
	function automatic tcp_status_t step_connection(inout conn_state_t st,
			input conn_cfg_t cfg, input tcp_event_t ev, output bit divided);
		tcp_status_t r;
		logic [31:0] buf32, adv, span, flight, share, n, incr, sq, divisor;
		logic [31:0] samp, s32, v32, d, rto32, floor2, mss32;
		logic [32:0] sum;
		r       = '0;
		divided = 1'b0;
		mss32   = {16'd0, cfg.mss};
		// buffer occupancy beyond the buffer size is meaningless; clip it
		buf32 = ({15'd0, ev.buffered} > 32'(DEF_BUFFER_BYTES)) ? 32'(DEF_BUFFER_BYTES)
			: {15'd0, ev.buffered};
		case (ev.action)
			ACT_OPEN: begin
				st.cwnd     = mss32;
				st.ssthresh = cfg.init_ssthresh;
				st.snd_una  = ev.value;
				st.snd_nxt  = ev.value;
				st.srtt     = '0;
				st.rttvar   = cfg.init_rttvar;
				st.rto      = cfg.init_rto;
				st.retries  = '0;
			end
			ACT_ACK: begin
				// modular compare: take only acks that cover new, sent data
				adv  = ev.value - st.snd_una;
				span = st.snd_nxt - st.snd_una;
				if (adv != 0 && adv <= span) begin
					st.snd_una = ev.value;
					st.retries = '0;
					if (st.cwnd < st.ssthresh) begin
						incr = mss32;
					end else begin
						sq      = mss32 * mss32;
						divisor = (st.cwnd == 0) ? 32'd1 : st.cwnd;
						incr    = sq / divisor;
						divided = 1'b1;
					end
					sum     = {1'b0, st.cwnd} + {1'b0, incr};
					st.cwnd = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
				end
			end
			ACT_RTT: begin
				samp = (ev.value > 32'd65535) ? 32'd65535 : ev.value;
				s32  = {16'd0, st.srtt};
				v32  = {16'd0, st.rttvar};
				if (s32 == 0) begin
					s32 = samp;
					v32 = samp >> 1;
				end else begin
					d   = (s32 > samp) ? s32 - samp : samp - s32;
					s32 = (7 * s32 + samp) / 8;
					v32 = (3 * v32 + d) / 4;
				end
				st.srtt   = s32[15:0];
				st.rttvar = v32[15:0];
				// floor first, ceiling last so a crossed pair ends at the ceiling
				rto32 = s32 + 4 * v32;
				if (rto32 < {16'd0, cfg.rto_min}) rto32 = {16'd0, cfg.rto_min};
				if (rto32 > {16'd0, cfg.rto_max}) rto32 = {16'd0, cfg.rto_max};
				st.rto = rto32[15:0];
			end
			ACT_TIMEOUT: begin
				floor2      = 2 * mss32;
				rto32       = 2 * {16'd0, st.rto};
				st.ssthresh = st.cwnd >> 1;
				if (st.ssthresh < floor2) st.ssthresh = floor2;
				st.cwnd = mss32;
				if (rto32 > {16'd0, cfg.rto_max}) rto32 = {16'd0, cfg.rto_max};
				st.rto = rto32[15:0];
				// resend from the oldest unacked byte, if anything is buffered
				n = (buf32 < mss32) ? buf32 : mss32;
				if (n != 0) begin
					r.send_len      = n[15:0];
					r.send_seq      = st.snd_una;
					r.is_retransmit = 1'b1;
					st.snd_nxt      = st.snd_una + n;
					if (st.retries != 8'hFF) st.retries = st.retries + 8'd1;
				end
			end
			ACT_SEND: begin
				flight = st.snd_nxt - st.snd_una;
				if (flight < st.cwnd) begin
					n     = st.cwnd - flight;
					share = (buf32 >= flight) ? buf32 - flight : 32'd0;
					if (share < n) n = share;
					if (mss32 < n) n = mss32;
					if (n != 0) begin
						r.send_len    = n[15:0];
						r.send_seq    = st.snd_nxt;
						r.send_offset = flight[16:0];
						st.snd_nxt    = st.snd_nxt + n;
					end
				end
			end
			default: begin
				// spare codes leave the connection alone
			end
		endcase
		r.window_now    = st.cwnd;
		r.threshold_now = st.ssthresh;
		r.timeout_now   = st.rto;
		r.retry_count   = st.retries;
		return r;
	endfunction

	task automatic flag_mismatch(input string what);
		if (error_count < PRINT_LIMIT) $display("[%0t] MISMATCH %s", $time, what);
		error_count++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			flag_mismatch($sformatf("result %0d %s: got 0x%0h, want 0x%0h",
				n_results, name, got, want));
	endtask

	// ------------------------------------------------------------------------
	// Driver: predict on every accepted transaction, then offer the next event
	// or idle. tvalid only moves after a transaction (or while low), and gets
	// one assignment per edge. Events 700..999 go out back to back.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : drive_events
		bit          divided;
		tcp_status_t status;
		bit          steady;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				status = step_connection(live_conn, cfg_shadow, event_on_bus, divided);
				expected_status.push_back(status);
				n_accepted++;
				if (status.send_len != 0) n_grants++;
				if (status.is_retransmit) n_retx++;
				if (divided) n_divisions++;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				steady = (n_accepted >= 700 && n_accepted < 1000);
				if (pending_events.size() != 0 && (steady || $urandom_range(99) >= GAP_PCT)) begin
					event_on_bus = pending_events.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata  <= {7'd0, event_on_bus.buffered, event_on_bus.value};
					s_axis_tuser  <= event_on_bus.action;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Monitor: unpack each result transaction and hold it against the oldest
	// prediction. Ready drops at random except across results 700..999.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : collect_status
		tcp_status_t got;
		tcp_status_t want;
		bit          steady;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.send_len      = m_axis_tdata[15:0];
				got.send_seq      = m_axis_tdata[47:16];
				got.send_offset   = m_axis_tdata[64:48];
				got.window_now    = m_axis_tdata[96:65];
				got.threshold_now = m_axis_tdata[128:97];
				got.timeout_now   = m_axis_tdata[144:129];
				got.retry_count   = m_axis_tdata[152:145];
				got.is_retransmit = m_axis_tuser;
				if (expected_status.size() == 0) begin
					flag_mismatch($sformatf("unexpected result, window 0x%0h len %0d",
						got.window_now, got.send_len));
				end else begin
					want = expected_status.pop_front();
					check_field("send_len", 32'(got.send_len), 32'(want.send_len));
					check_field("send_seq", got.send_seq, want.send_seq);
					check_field("send_offset", 32'(got.send_offset), 32'(want.send_offset));
					check_field("is_retransmit", 32'(got.is_retransmit),
						32'(want.is_retransmit));
					check_field("window_now", got.window_now, want.window_now);
					check_field("threshold_now", got.threshold_now, want.threshold_now);
					check_field("timeout_now", 32'(got.timeout_now), 32'(want.timeout_now));
					check_field("retry_count", 32'(got.retry_count), 32'(want.retry_count));
					n_results++;
				end
			end
			steady = (n_results >= 700 && n_results < 1000);
			m_axis_tready <= steady || ($urandom_range(99) >= GAP_PCT);
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------

	// Queue one event and advance the planner so later events can be built
	// against the real sequence pointers.
	task automatic queue_event(input logic [2:0] action, input logic [31:0] value,
			input logic [16:0] buffered);
		tcp_event_t ev;
		bit         unused;
		ev.action   = action;
		ev.value    = value;
		ev.buffered = buffered;
		void'(step_connection(plan_conn, cfg_shadow, ev, unused));
		pending_events.push_back(ev);
		n_queued++;
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= data;
		// only the register width is kept; unknown slots drop the write
		case (idx)
			REG_SEGMENT_SIZE:      cfg_shadow.mss           = data[15:0];
			REG_INITIAL_THRESHOLD: cfg_shadow.init_ssthresh = data;
			REG_INITIAL_VARIANCE:  cfg_shadow.init_rttvar   = data[15:0];
			REG_INITIAL_TIMEOUT:   cfg_shadow.init_rto      = data[15:0];
			REG_TIMEOUT_FLOOR:     cfg_shadow.rto_min       = data[15:0];
			REG_TIMEOUT_CEILING:   cfg_shadow.rto_max       = data[15:0];
			default: ;
		endcase
	endtask

	// Write all six registers back to back, then release the port.
	task automatic load_settings(input logic [31:0] mss, input logic [31:0] thresh,
			input logic [31:0] var0, input logic [31:0] rto0, input logic [31:0] rto_lo,
			input logic [31:0] rto_hi);
		write_reg(REG_SEGMENT_SIZE, mss);
		write_reg(REG_INITIAL_THRESHOLD, thresh);
		write_reg(REG_INITIAL_VARIANCE, var0);
		write_reg(REG_INITIAL_TIMEOUT, rto0);
		write_reg(REG_TIMEOUT_FLOOR, rto_lo);
		write_reg(REG_TIMEOUT_CEILING, rto_hi);
		@(posedge clk);
		cfg_we <= 1'b0;
		n_settings++;
		@(negedge clk);
	endtask

	// Wait until every queued event has produced its result, then let the
	// block settle before anything touches the registers.
	task automatic drain();
		do @(negedge clk); while (n_results != n_queued);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Mostly well-formed traffic: sends sized around what is in flight, acks
	// inside the outstanding span, RTT samples and some timeouts. The rest is
	// stale or future acks, re-opens and arbitrary events.
	task automatic run_sessions(input int n_events);
		logic [31:0] flight, val, room;
		logic [16:0] fill;
		int          pick;
		val = ($urandom_range(3) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 70000) : $urandom;
		queue_event(ACT_OPEN, val, 17'd0);
		for (int k = 0; k < n_events; k++) begin
			flight = plan_conn.snd_nxt - plan_conn.snd_una;
			room   = flight + $urandom_range(0, 3 * cfg_shadow.mss);
			if ($urandom_range(4) == 0) fill = 17'($urandom);
			else fill = (room > 32'h1FFFF) ? 17'h1FFFF : room[16:0];
			pick = $urandom_range(99);
			if (pick < 38) begin
				queue_event(ACT_SEND, $urandom, fill);
			end else if (pick < 70) begin
				if (flight != 0 && $urandom_range(9) != 0) begin
					val = plan_conn.snd_una +
						(($urandom_range(3) == 0) ? flight : $urandom_range(1, flight));
				end else begin
					case ($urandom_range(2))
						0:       val = plan_conn.snd_una;
						1:       val = plan_conn.snd_nxt + $urandom_range(1, 5000);
						default: val = $urandom;
					endcase
				end
				queue_event(ACT_ACK, val, 17'($urandom));
			end else if (pick < 82) begin
				val = ($urandom_range(9) == 0) ? $urandom : $urandom_range(0, 3000);
				queue_event(ACT_RTT, val, 17'($urandom));
			end else if (pick < 88) begin
				queue_event(ACT_TIMEOUT, $urandom, ($urandom_range(5) == 0) ? 17'd0 : fill);
			end else if (pick < 92) begin
				queue_event(ACT_OPEN, $urandom, 17'($urandom));
			end else begin
				queue_event(3'($urandom_range(7)), $urandom, 17'($urandom));
			end
		end
	endtask

	// ------------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------------
	initial begin : stimulus
		logic [31:0] mss_raw, thresh_raw, lo_raw, hi_raw;
		cfg_shadow = '{mss: RST_SEGMENT_SIZE, init_ssthresh: RST_INITIAL_THRESHOLD,
			init_rttvar: RST_INITIAL_VARIANCE, init_rto: RST_INITIAL_TIMEOUT,
			rto_min: RST_TIMEOUT_FLOOR, rto_max: RST_TIMEOUT_CEILING};
		live_conn = '{cwnd: 32'd1460, ssthresh: 32'd65535, snd_una: '0, snd_nxt: '0,
			srtt: '0, rttvar: 16'd250, rto: 16'd1000, retries: '0};
		plan_conn = live_conn;

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset settings, directed: send before any open, open near the
		// sequence wrap, empty and oversized buffers, buffer below in flight,
		// zero, future and wrapping acks, first and clipped RTT samples,
		// timeouts with and without data, spare codes, full ack.
		queue_event(ACT_SEND, 32'd0, 17'd0);
		queue_event(ACT_OPEN, 32'hFFFF_FF00, 17'd0);
		queue_event(ACT_SEND, 32'd0, 17'd0);
		queue_event(ACT_SEND, 32'hFFFF_FFFF, 17'h1FFFF);
		queue_event(ACT_SEND, 32'd0, 17'd100);
		queue_event(ACT_ACK, 32'hFFFF_FF00, 17'd0);
		queue_event(ACT_ACK, 32'hFFFF_FF00 + 32'd1461, 17'd0);
		queue_event(ACT_ACK, 32'hFFFF_FF00 + 32'd1000, 17'd0);
		queue_event(ACT_SEND, 32'd0, 17'd500);
		queue_event(ACT_RTT, 32'd0, 17'd0);
		queue_event(ACT_RTT, 32'd100, 17'd0);
		queue_event(ACT_RTT, 32'hFFFF_FFFF, 17'h1FFFF);
		queue_event(ACT_TIMEOUT, 32'd0, 17'd0);
		queue_event(ACT_TIMEOUT, 32'hFFFF_FFFF, 17'h10000);
		queue_event(ACT_SPARE_5, $urandom, 17'($urandom));
		queue_event(ACT_SPARE_6, $urandom, 17'($urandom));
		queue_event(ACT_SPARE_7, $urandom, 17'($urandom));
		queue_event(ACT_ACK, plan_conn.snd_nxt, 17'd0);
		drain();

		// One-byte segments, zero threshold; junk in the upper register bits
		// and writes to the unused slots must all be dropped. Leave one byte
		// in flight on a one-byte window.
		write_reg(REG_SPARE_6, 32'hFFFF_FFFF);
		write_reg(REG_SPARE_7, 32'h5A5A_5A5A);
		load_settings(32'hABCD_0001, 32'd0, 32'hFFFF_0007, 32'h1234_0100, 32'h8000_0000,
			32'h0001_FFFF);
		queue_event(ACT_OPEN, 32'hFFFF_FFFF, 17'd0);
		queue_event(ACT_SEND, 32'd0, 17'd5);
		queue_event(ACT_ACK, plan_conn.snd_nxt, 17'd0);
		queue_event(ACT_OPEN, 32'h7FFF_FFFF, 17'd0);
		queue_event(ACT_SEND, 32'd0, 17'd5);
		drain();

		// Zero segment size: the timeout collapses the window to zero, so the
		// following ack divides by a zero window in congestion avoidance.
		load_settings(32'hFFFF_0000, 32'd0, 32'd7, 32'd256, 32'd0, 32'hFFFF);
		queue_event(ACT_TIMEOUT, 32'd0, 17'd0);
		queue_event(ACT_ACK, plan_conn.snd_una + 32'd1, 17'd0);
		queue_event(ACT_TIMEOUT, 32'd0, 17'd100);
		queue_event(ACT_SEND, 32'd0, 17'd100);
		drain();

		// Upper extremes, with the RTO floor above the ceiling.
		load_settings(32'hFFFF, 32'hFFFF_FFFF, 32'hFFFF, 32'hFFFF, 32'hFFFF, 32'd0);
		run_sessions(200);
		drain();

		// Lower extremes: congestion avoidance until a timeout raises the threshold, floor zero.
		load_settings(32'd536, 32'd0, 32'd0, 32'd0, 32'd0, 32'hFFFF);
		run_sessions(200);
		drain();

		// Back-to-back timeouts with data pending: retry count climbs toward saturation and
		// the RTO climbs to the ceiling.
		load_settings(32'(RST_SEGMENT_SIZE), RST_INITIAL_THRESHOLD, 32'(RST_INITIAL_VARIANCE),
			32'(RST_INITIAL_TIMEOUT), 32'(RST_TIMEOUT_FLOOR), 32'(RST_TIMEOUT_CEILING));
		queue_event(ACT_OPEN, $urandom, 17'd0);
		for (int k = 0; k < 270; k++) begin
			if ($urandom_range(15) == 0)
				queue_event(ACT_RTT, $urandom_range(1, 5000), 17'($urandom));
			else
				queue_event(ACT_TIMEOUT, $urandom, 17'($urandom_range(1, 17'h1FFFF)));
		end
		queue_event(ACT_SEND, 32'd0, 17'h1FFFF);
		drain();

		// Random settings; upper register bits carry junk that must be masked.
		for (int ph = 0; ph < 5; ph++) begin
			case ($urandom_range(2))
				0:       mss_raw = $urandom_range(1, 64);
				1:       mss_raw = $urandom_range(256, 2000);
				default: mss_raw = $urandom_range(1, 65535);
			endcase
			mss_raw    = mss_raw | ($urandom & 32'hFFFF_0000);
			thresh_raw = ($urandom_range(3) == 0) ? $urandom : $urandom_range(0, 200000);
			lo_raw     = $urandom_range(0, 2000) | ($urandom & 32'hFFFF_0000);
			hi_raw     = ($urandom_range(4) == 0) ? $urandom
				: $urandom_range(2000, 65535) | ($urandom & 32'hFFFF_0000);
			load_settings(mss_raw, thresh_raw, $urandom, $urandom, lo_raw, hi_raw);
			run_sessions(180);
			drain();
		end

		if (expected_status.size() != 0)
			flag_mismatch($sformatf("%0d results never arrived", expected_status.size()));
		$display("summary: %0d events under %0d register settings, %0d results compared",
			n_accepted, n_settings + 1, n_results);
		$display("summary: %0d grants, %0d retransmissions, %0d avoidance divisions",
			n_grants, n_retx, n_divisions);
		if (error_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin : watchdog
		#2000000;
		$display("tb: failure");
		$finish;
	end

endmodule
